[rtl/ssa_pkg.sv]
// Shared types and constants for the seat slot allocator.
package ssa_pkg;

	localparam int CAP_W         = 7;
	localparam int CAP_MAX       = 2**CAP_W - 1;
	localparam int CAP_RESET     = 64;
	localparam int DEF_MAX_SLOTS = 64;
	localparam int DEF_ID_BITS   = 16;

	typedef enum logic [1:0] {
		CMD_RESERVE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BAD_ID   = 3'd2,
		ST_SEATED   = 3'd3,
		ST_BAD_SLOT = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] owner_id;
		logic [5:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [5:0]       granted_slot;
		logic [15:0]      slot_owner;
		logic [CAP_W-1:0] free_count;
		logic [CAP_W-1:0] used_count;
	} rsp_t;

	typedef struct packed {
		logic clr_init;
		logic clr_step;
		logic load;
		logic scan_run;
		logic fetch;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic reserve_go;
		logic access_go;
		logic scan_done;
	} dp_stat_t;

endpackage

[rtl/ssa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ssa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/ssa_ctrl.sv]
// Controller state machine that sequences clearing, scanning and lookups.
module ssa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_wr,
	input  ssa_pkg::dp_stat_t stat,
	output ssa_pkg::ctrl_cmd_t cmd,
	output logic              busy
);
	import ssa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_FETCH,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (stat.reserve_go) begin
					state_d = S_SCAN;
				end else if (stat.access_go) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_wr) begin
			cmd          = '0;
			cmd.clr_init = 1'b1;
			state_d      = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

[rtl/ssa_dp.sv]
// Datapath with the slot table, scan logic, free count and result register.
module ssa_dp #(
	parameter int MAX_SLOTS = ssa_pkg::DEF_MAX_SLOTS,
	parameter int ID_BITS   = ssa_pkg::DEF_ID_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssa_pkg::ctrl_cmd_t        cmd,
	input  ssa_pkg::req_t             request,
	input  logic [ssa_pkg::CAP_W-1:0] cap,
	output ssa_pkg::dp_stat_t         stat,
	output logic                      done,
	output ssa_pkg::rsp_t             result
);
	import ssa_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);

	logic [AW-1:0]      clr_addr_q;
	logic [CAP_W-1:0]   free_q;
	cmd_t               cmd_q;
	logic [ID_BITS-1:0] id_q;
	logic [5:0]         idx_q;
	logic [CAP_W-1:0]   scan_addr_q;
	logic               pend_s1;
	logic [CAP_W-1:0]   paddr_s1;
	logic               found_q;
	logic [CAP_W-1:0]   first_q;
	logic               dup_q;
	logic               done_q;
	rsp_t               res_q;

	logic               issue;
	logic               idx_bad;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ID_BITS-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ID_BITS-1:0] ram_rdata;
	status_t            st_d;
	logic [5:0]         granted_d;
	logic [15:0]        owner_d;
	logic [CAP_W-1:0]   free_d;
	logic               commit_d;

	assign issue   = cmd.scan_run && !dup_q && (scan_addr_q < cap);
	assign idx_bad = CAP_W'(idx_q) >= cap;

	assign stat.clr_last   = (clr_addr_q == AW'(MAX_SLOTS - 1));
	assign stat.reserve_go = (cmd_q == CMD_RESERVE) && (free_q != '0) && (id_q != '0);
	assign stat.access_go  = ((cmd_q == CMD_RELEASE) || (cmd_q == CMD_QUERY)) && !idx_bad;
	assign stat.scan_done  = !pend_s1 && (dup_q || (scan_addr_q >= cap));

	always_comb begin
		st_d      = ST_OK;
		granted_d = '0;
		owner_d   = '0;
		free_d    = free_q;
		commit_d  = 1'b0;
		unique case (cmd_q)
			CMD_RESERVE: begin
				priority if (free_q == '0) begin
					st_d = ST_FULL;
				end else if (id_q == '0) begin
					st_d = ST_BAD_ID;
				end else if (dup_q) begin
					st_d = ST_SEATED;
				end else if (!found_q) begin
					st_d = ST_FULL;
				end else begin
					granted_d = 6'(first_q);
					commit_d  = 1'b1;
					free_d    = free_q - CAP_W'(1);
				end
			end
			CMD_RELEASE: begin
				priority if (idx_bad) begin
					st_d = ST_BAD_SLOT;
				end else if (ram_rdata == '0) begin
					st_d = ST_EMPTY;
				end else begin
					owner_d  = 16'(ram_rdata);
					commit_d = 1'b1;
					if (free_q < cap) begin
						free_d = free_q + CAP_W'(1);
					end
				end
			end
			CMD_QUERY: begin
				if (idx_bad) begin
					st_d = ST_BAD_SLOT;
				end else begin
					owner_d = 16'(ram_rdata);
				end
			end
			CMD_NOP: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		ram_we    = cmd.clr_step || (cmd.finish && commit_d);
		ram_waddr = AW'(idx_q);
		ram_wdata = '0;
		if (cmd.clr_step) begin
			ram_waddr = clr_addr_q;
		end else if (cmd_q == CMD_RESERVE) begin
			ram_waddr = AW'(first_q);
			ram_wdata = id_q;
		end
		ram_re    = issue || cmd.fetch;
		ram_raddr = cmd.fetch ? AW'(idx_q) : AW'(scan_addr_q);
	end

	ssa_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(MAX_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			free_q      <= '0;
			scan_addr_q <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			dup_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clr_init) begin
				clr_addr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.clr_step) begin
				free_q <= cap;
			end else if (cmd.finish) begin
				free_q <= free_d;
			end
			if (cmd.load) begin
				scan_addr_q <= '0;
				pend_s1     <= 1'b0;
				found_q     <= 1'b0;
				dup_q       <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					scan_addr_q <= scan_addr_q + CAP_W'(1);
				end
				if (pend_s1) begin
					if (!found_q && (ram_rdata == '0)) begin
						found_q <= 1'b1;
					end
					if (ram_rdata == id_q) begin
						dup_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_t'(request.command);
			id_q  <= ID_BITS'(request.owner_id);
			idx_q <= request.slot_index;
		end
		paddr_s1 <= scan_addr_q;
		if (pend_s1 && !found_q && (ram_rdata == '0)) begin
			first_q <= paddr_s1;
		end
		if (cmd.finish) begin
			res_q.status       <= st_d;
			res_q.granted_slot <= granted_d;
			res_q.slot_owner   <= owner_d;
			res_q.free_count   <= free_d;
			res_q.used_count   <= cap - free_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/seat_slot_allocator_unit.sv]
// Top level of the seat slot allocator: configuration port, controller and datapath.
// A scanning reserve reads the slots below the capacity in order and stops early once the id is
// found seated; a full table or a zero id skips the scan, an in-range release or query reads
// its one slot, and any other request goes straight to its result. The next request is taken in the
// cycle its predecessor's result is shown for one cycle on done; the receiver cannot stall it.
// Reset and each nonzero capacity write start a clearing pass over every slot that holds busy.
module seat_slot_allocator_unit #(
	parameter int MAX_SLOTS = ssa_pkg::DEF_MAX_SLOTS,
	parameter int ID_BITS   = ssa_pkg::DEF_ID_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ssa_pkg::req_t request,
	output logic          done,
	output ssa_pkg::rsp_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import ssa_pkg::*;

	localparam logic [CAP_W-1:0] CAP_LIMIT =
		(MAX_SLOTS > CAP_MAX) ? CAP_W'(CAP_MAX) : CAP_W'(MAX_SLOTS);
	localparam logic [CAP_W-1:0] CAP_INIT =
		(CAP_RESET > int'(CAP_LIMIT)) ? CAP_LIMIT : CAP_W'(CAP_RESET);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] wval;
	logic             cfg_wr;
	ctrl_cmd_t        cmd;
	dp_stat_t         stat;

	assign wval   = pwdata[CAP_W-1:0];
	assign cfg_wr = psel && penable && pwrite && !paddr[2] && (wval != '0);
	assign pready = 1'b1;
	assign prdata = 32'(cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_INIT;
		end else if (cfg_wr) begin
			cap_q <= (wval > CAP_LIMIT) ? CAP_LIMIT : wval;
		end
	end

	ssa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_wr (cfg_wr),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssa_dp #(
		.MAX_SLOTS(MAX_SLOTS),
		.ID_BITS  (ID_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.cap     (cap_q),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule
